// File: rtl/ttu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttu_pkg;

	localparam int unsigned VALUE_BITS = 64;
	localparam int unsigned BASE_BITS  = 6;
	localparam int unsigned DIGIT_BITS = 6;
	localparam int unsigned POS_BITS   = 16;
	localparam int unsigned PROD_BITS  = VALUE_BITS + BASE_BITS;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);
	localparam logic [BASE_BITS-1:0] BASE_MAX   = BASE_BITS'(36);
	localparam logic [BASE_BITS-1:0] BASE_ONE   = BASE_BITS'(1);
	localparam logic [BASE_BITS-1:0] BASE_AUTO  = BASE_BITS'(0);
	localparam logic [BASE_BITS-1:0] BASE_OCT   = BASE_BITS'(8);
	localparam logic [BASE_BITS-1:0] BASE_DEC   = BASE_BITS'(10);
	localparam logic [BASE_BITS-1:0] BASE_HEX   = BASE_BITS'(16);

	localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = DIGIT_BITS'(36);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_RANGE   = 2'd2;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_SIGNED,
		PH_ZERO,
		PH_ZEROX,
		PH_DIGITS,
		PH_DONE,
		PH_FAIL
	} phase_t;

	typedef enum logic [1:0] {
		EMIT_ZERO,
		EMIT_INVALID,
		EMIT_NUMBER
	} emit_kind_t;

	typedef struct packed {
		logic                  accept;
		logic                  is_term;
		logic                  is_blank;
		logic                  is_sign;
		logic                  is_minus;
		logic                  is_zero;
		logic                  is_x;
		logic [DIGIT_BITS-1:0] digit;
		logic [BASE_BITS-1:0]  cfg_base;
		logic [BASE_BITS-1:0]  eff_base;
		logic                  digit_seen;
	} dp_status_t;

	typedef struct packed {
		logic                 advance;
		logic                 load_base;
		logic [BASE_BITS-1:0] base;
		logic                 take;
		logic                 zero_mark;
		logic                 set_neg;
		logic                 emit;
		emit_kind_t           emit_kind;
		logic                 clear;
	} dp_cmd_t;

	function automatic logic [DIGIT_BITS-1:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'(DIGIT_NONE);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = c - CH_LA + 8'd10;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = c - CH_UA + 8'd10;
		end
		return d[DIGIT_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/ttu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ttu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ttu_pkg::dp_status_t sts,
	output ttu_pkg::dp_cmd_t       cmd
);

	ttu_pkg::phase_t state_q;
	ttu_pkg::phase_t state_d;

	logic [ttu_pkg::BASE_BITS-1:0] raw_base;
	logic [ttu_pkg::BASE_BITS-1:0] start_base;
	logic [ttu_pkg::BASE_BITS-1:0] zero_base;
	logic                          cfg_bad;
	logic                          zero_path;
	logic                          ok_start;
	logic                          ok_zero;
	logic                          ok_eff;
	logic                          ok_hex;
	logic                          step;

	always_comb begin
		raw_base   = (state_q == ttu_pkg::PH_SPACE) ? sts.cfg_base : sts.eff_base;
		start_base = (raw_base == ttu_pkg::BASE_AUTO) ? ttu_pkg::BASE_DEC : raw_base;
		zero_base  = (sts.eff_base == ttu_pkg::BASE_AUTO) ? ttu_pkg::BASE_OCT : sts.eff_base;
		cfg_bad    = (sts.cfg_base == ttu_pkg::BASE_ONE) || (sts.cfg_base > ttu_pkg::BASE_MAX);
		zero_path  = sts.is_zero &&
			((raw_base == ttu_pkg::BASE_AUTO) || (raw_base == ttu_pkg::BASE_HEX));
		ok_start   = sts.digit < start_base;
		ok_zero    = sts.digit < zero_base;
		ok_eff     = sts.digit < sts.eff_base;
		ok_hex     = sts.digit < ttu_pkg::BASE_HEX;
		step       = sts.accept && !sts.is_term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttu_pkg::PH_SPACE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		if (sts.accept && sts.is_term) begin
			state_d = ttu_pkg::PH_SPACE;
		end else if (step) begin
			case (state_q)
				ttu_pkg::PH_SPACE: begin
					if (sts.is_blank) begin
						state_d = ttu_pkg::PH_SPACE;
					end else if (cfg_bad) begin
						state_d = ttu_pkg::PH_FAIL;
					end else if (sts.is_sign) begin
						state_d = ttu_pkg::PH_SIGNED;
					end else if (zero_path) begin
						state_d = ttu_pkg::PH_ZERO;
					end else if (ok_start) begin
						state_d = ttu_pkg::PH_DIGITS;
					end else begin
						state_d = ttu_pkg::PH_DONE;
					end
				end
				ttu_pkg::PH_SIGNED: begin
					if (zero_path) begin
						state_d = ttu_pkg::PH_ZERO;
					end else if (ok_start) begin
						state_d = ttu_pkg::PH_DIGITS;
					end else begin
						state_d = ttu_pkg::PH_FAIL;
					end
				end
				ttu_pkg::PH_ZERO: begin
					if (sts.is_x) begin
						state_d = ttu_pkg::PH_ZEROX;
					end else if (ok_zero) begin
						state_d = ttu_pkg::PH_DIGITS;
					end else begin
						state_d = ttu_pkg::PH_DONE;
					end
				end
				ttu_pkg::PH_ZEROX: begin
					state_d = ok_hex ? ttu_pkg::PH_DIGITS : ttu_pkg::PH_DONE;
				end
				ttu_pkg::PH_DIGITS: begin
					state_d = ok_eff ? ttu_pkg::PH_DIGITS : ttu_pkg::PH_DONE;
				end
				default: begin
					state_d = state_q;
				end
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.emit_kind = ttu_pkg::EMIT_ZERO;
		if (sts.accept && sts.is_term) begin
			cmd.emit  = 1'b1;
			cmd.clear = 1'b1;
			case (state_q)
				ttu_pkg::PH_SPACE: begin
					cmd.emit_kind = cfg_bad ? ttu_pkg::EMIT_INVALID : ttu_pkg::EMIT_ZERO;
				end
				ttu_pkg::PH_SIGNED, ttu_pkg::PH_FAIL: begin
					cmd.emit_kind = ttu_pkg::EMIT_INVALID;
				end
				default: begin
					cmd.emit_kind = sts.digit_seen ? ttu_pkg::EMIT_NUMBER : ttu_pkg::EMIT_ZERO;
				end
			endcase
		end else if (step) begin
			cmd.advance = 1'b1;
			case (state_q)
				ttu_pkg::PH_SPACE, ttu_pkg::PH_SIGNED: begin
					if (state_q == ttu_pkg::PH_SPACE && (sts.is_blank || cfg_bad)) begin
						cmd.load_base = 1'b0;
					end else if (state_q == ttu_pkg::PH_SPACE && sts.is_sign) begin
						cmd.load_base = 1'b1;
						cmd.base      = raw_base;
						cmd.set_neg   = sts.is_minus;
					end else if (zero_path) begin
						cmd.load_base = 1'b1;
						cmd.base      = raw_base;
						cmd.zero_mark = 1'b1;
					end else begin
						cmd.load_base = 1'b1;
						cmd.base      = start_base;
						cmd.take      = ok_start;
					end
				end
				ttu_pkg::PH_ZERO: begin
					if (!sts.is_x) begin
						cmd.load_base = 1'b1;
						cmd.base      = zero_base;
						cmd.take      = ok_zero;
					end
				end
				ttu_pkg::PH_ZEROX: begin
					cmd.load_base = ok_hex;
					cmd.base      = ttu_pkg::BASE_HEX;
					cmd.take      = ok_hex;
				end
				ttu_pkg::PH_DIGITS: begin
					cmd.base = sts.eff_base;
					cmd.take = ok_eff;
				end
				default: begin
					cmd.advance = 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/ttu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ttu_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [7:0]                          text_char,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [ttu_pkg::VALUE_BITS-1:0]           parsed_value,
	output logic [1:0]                               parse_status,
	output logic [15:0]                              stop_position,
	input  wire logic                                cfg_wr_en,
	input  wire logic [ttu_pkg::BASE_BITS-1:0]       cfg_wr_data,
	input  wire ttu_pkg::dp_cmd_t                    cmd,
	output ttu_pkg::dp_status_t                      sts
);

	logic [ttu_pkg::BASE_BITS-1:0]  cfg_base_q;
	logic [ttu_pkg::BASE_BITS-1:0]  eff_base_q;
	logic                           neg_q;
	logic [ttu_pkg::VALUE_BITS-1:0] acc_q;
	logic                           ovf_q;
	logic [ttu_pkg::POS_BITS-1:0]   pos_q;
	logic [ttu_pkg::POS_BITS-1:0]   end_q;
	logic                           seen_q;

	logic                           out_valid_q;
	logic [ttu_pkg::VALUE_BITS-1:0] value_q;
	logic [1:0]                     status_q;
	logic [15:0]                    stop_q;

	logic [ttu_pkg::DIGIT_BITS-1:0] digit;
	logic [ttu_pkg::PROD_BITS-1:0]  sum;
	logic [ttu_pkg::POS_BITS-1:0]   pos_next;
	logic                           accept;
	logic                           out_take;

	always_comb begin
		in_stall = out_valid_q && out_stall;
		accept   = in_valid && !in_stall;
		out_take = out_valid_q && !out_stall;
		digit    = ttu_pkg::digit_value(text_char);
		sum      = ttu_pkg::PROD_BITS'(acc_q) * ttu_pkg::PROD_BITS'(cmd.base) +
			ttu_pkg::PROD_BITS'(digit);
		pos_next = (pos_q == ttu_pkg::POS_MAX) ? ttu_pkg::POS_MAX : pos_q + 1'b1;

		sts            = '0;
		sts.accept     = accept;
		sts.is_term    = text_char == ttu_pkg::CH_NUL;
		sts.is_blank   = (text_char == ttu_pkg::CH_SPACE) ||
			(text_char >= ttu_pkg::CH_TAB && text_char <= ttu_pkg::CH_CR);
		sts.is_sign    = (text_char == ttu_pkg::CH_PLUS) || (text_char == ttu_pkg::CH_MINUS);
		sts.is_minus   = text_char == ttu_pkg::CH_MINUS;
		sts.is_zero    = text_char == ttu_pkg::CH_ZERO;
		sts.is_x       = (text_char == ttu_pkg::CH_LX) || (text_char == ttu_pkg::CH_UX);
		sts.digit      = digit;
		sts.cfg_base   = cfg_base_q;
		sts.eff_base   = eff_base_q;
		sts.digit_seen = seen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_base_q <= ttu_pkg::BASE_RESET;
		end else if (cfg_wr_en) begin
			cfg_base_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_base_q <= '0;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			ovf_q      <= 1'b0;
			pos_q      <= '0;
			end_q      <= '0;
			seen_q     <= 1'b0;
		end else if (cmd.clear) begin
			eff_base_q <= '0;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			ovf_q      <= 1'b0;
			pos_q      <= '0;
			end_q      <= '0;
			seen_q     <= 1'b0;
		end else begin
			if (cmd.advance) begin
				pos_q <= pos_next;
			end
			if (cmd.load_base) begin
				eff_base_q <= cmd.base;
			end
			if (cmd.set_neg) begin
				neg_q <= 1'b1;
			end
			if (cmd.zero_mark) begin
				acc_q  <= '0;
				seen_q <= 1'b1;
				end_q  <= pos_next;
			end
			if (cmd.take) begin
				if (!ovf_q) begin
					acc_q <= sum[ttu_pkg::VALUE_BITS-1:0];
					ovf_q <= |sum[ttu_pkg::PROD_BITS-1:ttu_pkg::VALUE_BITS];
				end
				seen_q <= 1'b1;
				end_q  <= pos_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.emit_kind)
				ttu_pkg::EMIT_INVALID: begin
					value_q  <= '0;
					status_q <= ttu_pkg::STATUS_INVALID;
					stop_q   <= '0;
				end
				ttu_pkg::EMIT_NUMBER: begin
					stop_q <= 16'(end_q);
					if (ovf_q) begin
						value_q  <= '1;
						status_q <= ttu_pkg::STATUS_RANGE;
					end else begin
						value_q  <= neg_q ? (~acc_q + 1'b1) : acc_q;
						status_q <= ttu_pkg::STATUS_OK;
					end
				end
				default: begin
					value_q  <= '0;
					status_q <= ttu_pkg::STATUS_OK;
					stop_q   <= '0;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign parsed_value  = value_q;
	assign parse_status  = status_q;
	assign stop_position = stop_q;

endmodule

`default_nettype wire

// File: rtl/text_to_unsigned_parser_top.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    text_char[7:0]
// result    out        out_valid / out_stall  parsed_value[63:0], parse_status[1:0],
//                                             stop_position[15:0]
// config    in         cfg_wr_en              cfg_wr_data[5:0] (number_base)
//
// One character word per cycle while in_stall is low; the 64x6 multiply-add on the accumulator sets the cycle.
// A zero byte yields its result word in the cycle after acceptance, from the output register.
// in_stall rises only while a result word waits and out_stall is high.
// Reset sets number_base to 10 and clears the parse state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module text_to_unsigned_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  text_char,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      parsed_value,
	output logic [1:0]       parse_status,
	output logic [15:0]      stop_position,
	input  wire logic        cfg_wr_en,
	input  wire logic [5:0]  cfg_wr_data
);

	ttu_pkg::dp_cmd_t    cmd;
	ttu_pkg::dp_status_t sts;

	ttu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ttu_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.text_char     (text_char),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.parsed_value  (parsed_value),
		.parse_status  (parse_status),
		.stop_position (stop_position),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

`default_nettype wire

// File: tb/sv/ttu_result_check.sv
`timescale 1ns / 1ps

module ttu_result_check
	import ttu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  text_char,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] parsed_value,
	input  logic [1:0]  parse_status,
	input  logic [15:0] stop_position,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,
	output int          fail_count,
	output int          outstanding
);

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
		logic [15:0] stop;
	} parse_result_t;

	parse_result_t pending_parses[$];

	logic [BASE_BITS-1:0] base_reg;
	phase_t               scan_phase;
	logic                 minus_seen;
	logic [BASE_BITS-1:0] radix;
	logic [63:0]          acc;
	logic                 ovf;
	logic [15:0]          char_pos;
	logic [15:0]          stop_pos;
	logic                 have_digit;

	function automatic logic [5:0] char_digit(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			return 6'(c - CH_ZERO);
		end
		if (c >= CH_LA && c <= CH_LZ) begin
			return 6'(c - CH_LA + 8'd10);
		end
		if (c >= CH_UA && c <= CH_UZ) begin
			return 6'(c - CH_UA + 8'd10);
		end
		return DIGIT_NONE;
	endfunction

	function automatic logic bad_base(input logic [BASE_BITS-1:0] b);
		return b == BASE_ONE || b > BASE_MAX;
	endfunction

	function automatic logic [15:0] bump(input logic [15:0] p);
		return (p == 16'hFFFF) ? p : p + 16'd1;
	endfunction

	task automatic clear_parse();
		scan_phase = PH_SPACE;
		minus_seen = 1'b0;
		radix = BASE_AUTO;
		acc = '0;
		ovf = 1'b0;
		char_pos = '0;
		stop_pos = '0;
		have_digit = 1'b0;
	endtask

	task automatic add_digit(input logic [5:0] d);
		logic [71:0] prod;
		if (!ovf) begin
			prod = 72'(acc) * 72'(radix) + 72'(d);
			if (radix == BASE_AUTO || prod[71:64] != 8'd0) begin
				ovf = 1'b1;
			end
			acc = prod[63:0];
		end
		have_digit = 1'b1;
		stop_pos = bump(char_pos);
		scan_phase = PH_DIGITS;
	endtask

	task automatic settled_char(input logic [7:0] c);
		logic [5:0] d;
		d = char_digit(c);
		if (d < radix) begin
			add_digit(d);
		end else if (have_digit) begin
			scan_phase = PH_DONE;
		end else if (scan_phase == PH_SIGNED) begin
			scan_phase = PH_FAIL;
		end else begin
			scan_phase = PH_DONE;
		end
	endtask

	task automatic number_first(input logic [7:0] c);
		if (c == CH_ZERO && (radix == BASE_AUTO || radix == BASE_HEX)) begin
			acc = '0;
			have_digit = 1'b1;
			stop_pos = bump(char_pos);
			scan_phase = PH_ZERO;
		end else begin
			if (radix == BASE_AUTO) begin
				radix = BASE_DEC;
			end
			settled_char(c);
		end
	endtask

	task automatic advance_char(input logic [7:0] c);
		case (scan_phase)
			PH_SPACE: begin
				if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
					if (bad_base(base_reg)) begin
						scan_phase = PH_FAIL;
					end else begin
						radix = base_reg;
						if (c == CH_PLUS || c == CH_MINUS) begin
							minus_seen = (c == CH_MINUS);
							scan_phase = PH_SIGNED;
						end else begin
							number_first(c);
						end
					end
				end
			end
			PH_SIGNED: number_first(c);
			PH_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					scan_phase = PH_ZEROX;
				end else begin
					if (radix == BASE_AUTO) begin
						radix = BASE_OCT;
					end
					settled_char(c);
				end
			end
			PH_ZEROX: begin
				if (char_digit(c) < 6'd16) begin
					radix = BASE_HEX;
					add_digit(char_digit(c));
				end else begin
					scan_phase = PH_DONE;
				end
			end
			PH_DIGITS: settled_char(c);
			default: ;
		endcase
		char_pos = bump(char_pos);
	endtask

	task automatic close_string(output parse_result_t r);
		r = '0;
		r.status = STATUS_OK;
		if (scan_phase == PH_SPACE) begin
			if (bad_base(base_reg)) begin
				r.status = STATUS_INVALID;
			end
		end else if (scan_phase == PH_FAIL || scan_phase == PH_SIGNED) begin
			r.status = STATUS_INVALID;
		end else if (have_digit) begin
			r.stop = stop_pos;
			if (ovf) begin
				r.value = '1;
				r.status = STATUS_RANGE;
			end else begin
				r.value = minus_seen ? (64'd0 - acc) : acc;
			end
		end
		clear_parse();
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		parse_result_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			base_reg = BASE_RESET;
			clear_parse();
			pending_parses.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_parses.size() == 0) begin
					$error("unexpected result word: value %h status %0d stop %0d",
						parsed_value, parse_status, stop_position);
					errs++;
				end else begin
					want = pending_parses.pop_front();
					if (parsed_value !== want.value) begin
						$error("parsed_value: expected %h, actual %h", want.value, parsed_value);
						errs++;
					end
					if (parse_status !== want.status) begin
						$error("parse_status: expected %0d, actual %0d", want.status,
							parse_status);
						errs++;
					end
					if (stop_position !== want.stop) begin
						$error("stop_position: expected %0d, actual %0d", want.stop,
							stop_position);
						errs++;
					end
				end
			end
			if (cfg_wr_en) begin
				base_reg = cfg_wr_data;
			end
			if (in_valid && !in_stall) begin
				if (text_char == CH_NUL) begin
					close_string(want);
					pending_parses.push_back(want);
				end else begin
					advance_char(text_char);
				end
			end
			fail_count <= fail_count + errs;
			outstanding <= pending_parses.size();
		end
	end

endmodule

// File: tb/sv/text_to_unsigned_parser_top_test.sv
`timescale 1ns / 1ps

module text_to_unsigned_parser_top_test;
	import ttu_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  text_char;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] parsed_value;
	logic [1:0]  parse_status;
	logic [15:0] stop_position;
	logic        cfg_wr_en;
	logic [5:0]  cfg_wr_data;

	int result_fails;
	int results_waiting;
	int send_gap_pct;
	int recv_stall_pct;
	logic hold_req;
	logic [BASE_BITS-1:0] cur_base;

	text_to_unsigned_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.text_char     (text_char),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.parsed_value  (parsed_value),
		.parse_status  (parse_status),
		.stop_position (stop_position),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	ttu_result_check result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.text_char     (text_char),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.parsed_value  (parsed_value),
		.parse_status  (parse_status),
		.stop_position (stop_position),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fail_count    (result_fails),
		.outstanding   (results_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("text_to_unsigned_parser_top_test: FAIL");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		hold_req = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_word(input logic [7:0] c);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		text_char <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_word(s[i]);
		end
		send_word(CH_NUL);
	endtask

	// hold until every expected result has come back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_waiting != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_base(input logic [BASE_BITS-1:0] b);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= b;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_base = b;
	endtask

	function automatic logic [BASE_BITS-1:0] pick_base();
		case ($urandom_range(10))
			0: return BASE_AUTO;
			1: return 6'd2;
			2: return BASE_OCT;
			3: return BASE_DEC;
			4: return BASE_HEX;
			5: return BASE_MAX;
			6: return BASE_AUTO;
			7: return BASE_ONE;
			8: return 6'd63;
			9: return 6'd37;
			default: return 6'($urandom_range(63));
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		return ($urandom_range(6) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4));
	endfunction

	function automatic logic [7:0] digit_char(input logic [5:0] d);
		if (d < 6'd10) begin
			return 8'(CH_ZERO + d);
		end
		return 8'(($urandom_range(1) ? CH_UA : CH_LA) + d - 8'd10);
	endfunction

	task automatic send_random_string(inout int count);
		logic [7:0] text[$];
		logic [BASE_BITS-1:0] radix;
		logic lead;
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 70) begin
			lead = 1'b0;
			repeat ($urandom_range(1) ? 0 : $urandom_range(3, 1)) text.push_back(blank_char());
			case ($urandom_range(2))
				1: text.push_back(CH_PLUS);
				2: text.push_back(CH_MINUS);
				default: ;
			endcase
			if (cur_base == BASE_AUTO) begin
				case ($urandom_range(2))
					0: begin
						text.push_back(CH_ZERO);
						text.push_back($urandom_range(1) ? CH_LX : CH_UX);
						radix = BASE_HEX;
					end
					1: begin
						text.push_back(CH_ZERO);
						radix = BASE_OCT;
					end
					default: begin
						radix = BASE_DEC;
						lead = 1'b1;
					end
				endcase
			end else if (cur_base == BASE_ONE || cur_base > BASE_MAX) begin
				radix = BASE_DEC;
			end else begin
				radix = cur_base;
				if (radix == BASE_HEX && $urandom_range(1)) begin
					text.push_back(CH_ZERO);
					text.push_back($urandom_range(1) ? CH_LX : CH_UX);
				end
			end
			kind = $urandom_range(99);
			n = (kind < 70) ? $urandom_range(12, 1) :
				(kind < 90) ? $urandom_range(25, 13) : $urandom_range(70, 40);
			if (lead) begin
				text.push_back(digit_char(6'($urandom_range(9, 1))));
				n--;
			end
			repeat (n) text.push_back(digit_char(6'($urandom_range(radix - 1))));
			if ($urandom_range(9) < 3) begin
				repeat ($urandom_range(3, 1)) text.push_back(8'($urandom_range(255, 1)));
			end
		end else if (kind < 85) begin
			case ($urandom_range(5))
				0: repeat ($urandom_range(3)) text.push_back(blank_char());
				1: text.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
				2: begin
					text.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
					text.push_back(8'($urandom_range(255, 1)));
				end
				3: begin
					text.push_back(CH_ZERO);
					text.push_back($urandom_range(1) ? CH_LX : CH_UX);
					text.push_back(8'($urandom_range(255, 1)));
				end
				4: begin
					text.push_back(CH_ZERO);
					text.push_back(8'(CH_ZERO + 8'd8 + $urandom_range(1)));
				end
				default: text.push_back(8'($urandom_range(126, 33)));
			endcase
		end else begin
			repeat ($urandom_range(8, 1)) text.push_back(8'($urandom_range(255, 1)));
		end
		text.push_back(CH_NUL);
		foreach (text[i]) begin
			send_word(text[i]);
		end
		count += text.size();
	endtask

	task automatic run_random(input int words);
		int count;
		int strings;
		count = 0;
		strings = 0;
		while (count < words) begin
			send_random_string(count);
			strings++;
			if (strings % 10 == 0) begin
				set_base(pick_base());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		text_char = 8'h00;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 6'd0;
		send_gap_pct = 11;
		recv_stall_pct = 64;
		cur_base = BASE_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("");
		send_text(" -");
		set_base(BASE_AUTO);
		send_text("0");
		send_text("0x");
		send_text("09");
		set_base(BASE_ONE);
		send_text("5");
		set_base(BASE_MAX);
		send_word(CH_MINUS);
		send_word(CH_LZ);
		send_word(CH_UZ);
		send_word(8'hFF);
		send_word(CH_NUL);
		send_text("zzzzzzzzzzzzz");
		set_base(6'd63);
		send_text("\t");

		run_random(200);
		hold_req = 1'b1;
		run_random(250);

		send_gap_pct = 64;
		recv_stall_pct = 11;
		run_random(250);
		drain();
		run_random(250);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		run_random(450);

		drain();
		repeat (16) @(posedge clk);
		if (result_fails == 0) begin
			$display("text_to_unsigned_parser_top_test: PASS");
		end else begin
			$display("text_to_unsigned_parser_top_test: FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/ttu_pkg.sv
rtl/ttu_ctrl.sv
rtl/ttu_datapath.sv
rtl/text_to_unsigned_parser_top.sv
tb/sv/ttu_result_check.sv
tb/sv/text_to_unsigned_parser_top_test.sv
